### rtl/cac_pkg.sv
// Shared types, constants and codes of the concurrency admission controller.
package cac_pkg;

  localparam int unsigned ClientSlots   = 16;
  localparam int unsigned InflightDepth = 64;
  localparam int unsigned SlotW  = $clog2(ClientSlots);
  localparam int unsigned InfW   = $clog2(InflightDepth);
  localparam int unsigned InfCntW = $clog2(InflightDepth + 1);
  localparam int unsigned ActW   = $clog2(ClientSlots + 1);
  localparam int unsigned TotW   = 14;

  localparam logic [6:0] RstMaxTotal     = 7'd40;
  localparam logic [9:0] RstMaxFixed     = 10'd25;
  localparam logic [6:0] RstMaxSameDev   = 7'd4;

  typedef enum logic [2:0] {
    KIND_REG_FIXED = 3'd0,
    KIND_REG_DISC  = 3'd1,
    KIND_UNREG     = 3'd2,
    KIND_REQUEST   = 3'd3,
    KIND_FINISH    = 3'd4,
    KIND_DENIED    = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    CFG_MAX_TOTAL    = 2'd0,
    CFG_MAX_FIXED    = 2'd1,
    CFG_MAX_SAME_DEV = 2'd2
  } cfg_idx_e;

  // Sequencer states of the core.
  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_DEC, ST_SUM_RD, ST_SUM, ST_FQ_RD, ST_FQ_CHK, ST_FQ_DIV,
    ST_FQ_WR, ST_DS, ST_DS_DIV, ST_SCAN_RD, ST_SCAN, ST_SH_RD, ST_SH_WR, ST_OUT
  } st_e;

  // Per-slot record held in the slot memory.
  typedef struct packed {
    logic       is_fixed;
    logic [6:0] jobs;
    logic [9:0] declared;
    logic [9:0] quota;
  } slot_t;

  // Divider handshake.
  typedef struct packed {
    logic            start;
    logic [TotW+9:0] num;
    logic [TotW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [TotW+9:0] quo;
  } div_rsp_t;

endpackage

### rtl/cac_div.sv
// Restoring divider, one quotient bit per cycle.
module cac_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cac_pkg::div_req_t req_i,
  output cac_pkg::div_rsp_t rsp_o
);
  localparam int unsigned NW = cac_pkg::TotW + 10;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q, quo_d;
  logic [cac_pkg::TotW:0] rem_q, rem_d;
  logic [cac_pkg::TotW-1:0] den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [cac_pkg::TotW:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[cac_pkg::TotW-1:0], quo_q[NW-1]};
    if (req_i.start) begin
      quo_d = req_i.num; rem_d = '0; den_d = req_i.den;
      cnt_d = CW'(NW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule

### rtl/concurrency_admission_controller_core.sv
// Top level: slot and in-flight memories, sequencer, shared divider.
// A new registration or an unregister walks the slot memory twice (sum, then fixed
// quotas, with a divide where the fixed total is over its limit and a write-back per
// fixed slot), then may run the discovery divide; request and finish scan the in-flight
// memory, and finish also shifts the tail down.
// One item at a time; the next is taken once the result register is free.
// Reset: async active low; slot valid bits clear at once, memories need no sweep.
module concurrency_admission_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // client_id[3:0], device_id[35:4], device_count[45:36]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // active_clients[4:0]
  output logic        m_axis_tuser,  // granted
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);
  localparam int unsigned SW = cac_pkg::SlotW;
  localparam int unsigned IW = cac_pkg::InfW;
  localparam int unsigned CW = cac_pkg::InfCntW;
  localparam int unsigned TW = cac_pkg::TotW;

  cac_pkg::st_e st_q, st_d;

  // configuration
  logic [6:0] max_total_q;
  logic [9:0] max_fixed_q;
  logic [6:0] max_same_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_total_q <= cac_pkg::RstMaxTotal;
      max_fixed_q <= cac_pkg::RstMaxFixed;
      max_same_q  <= cac_pkg::RstMaxSameDev;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cac_pkg::CFG_MAX_TOTAL:    max_total_q <= cfg_data_i[6:0];
        cac_pkg::CFG_MAX_FIXED:    max_fixed_q <= cfg_data_i;
        cac_pkg::CFG_MAX_SAME_DEV: max_same_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // memories
  cac_pkg::slot_t slot_mem [cac_pkg::ClientSlots];
  logic [31:0]    inf_mem  [cac_pkg::InflightDepth];
  cac_pkg::slot_t slot_rd_q;
  logic [31:0]    inf_rd_q;
  logic           slot_we;
  logic [SW-1:0]  slot_ra, slot_wa;
  cac_pkg::slot_t slot_wd;
  logic           inf_we;
  logic [IW-1:0]  inf_ra, inf_wa;
  logic [31:0]    inf_wd;

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd_q <= slot_mem[slot_ra];
    if (inf_we) inf_mem[inf_wa] <= inf_wd;
    inf_rd_q <= inf_mem[inf_ra];
  end

  // control state
  logic [cac_pkg::ClientSlots-1:0] valid_q, valid_d;
  logic [6:0] disc_q, disc_d;
  logic [CW-1:0] icnt_q, icnt_d;
  logic [2:0] kind_q, kind_d;
  logic [SW-1:0] cid_q, cid_d;
  logic [31:0] dev_q, dev_d;
  logic [9:0] cnt_q, cnt_d;
  logic [SW:0] idx_q, idx_d;
  logic [CW-1:0] sidx_q, sidx_d;
  logic [6:0] match_q, match_d;
  logic [TW-1:0] tot_q, tot_d;
  logic [SW:0] ndisc_q, ndisc_d;
  logic known_q, known_d, gr_q, gr_d, ov_q, ov_d;
  cac_pkg::slot_t cur_q, cur_d;
  logic [cac_pkg::ActW-1:0] act_q, act_d;

  cac_pkg::div_req_t dreq;
  cac_pkg::div_rsp_t drsp;
  cac_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic [SW-1:0] idx_s;
  assign idx_s = idx_q[SW-1:0];
  logic [TW-1:0] ref_v;
  logic [9:0]    lim;
  logic [9:0]    q_v;

  assign s_axis_tready = (st_q == cac_pkg::ST_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {{(8-cac_pkg::ActW){1'b0}}, act_q};
  assign m_axis_tuser  = gr_q;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      cac_pkg::ST_IDLE:
        if (s_axis_tvalid && s_axis_tready) st_d = cac_pkg::ST_RD;
      cac_pkg::ST_RD:      st_d = cac_pkg::ST_DEC;
      cac_pkg::ST_DEC: begin
        priority case (kind_q)
          cac_pkg::KIND_REG_FIXED, cac_pkg::KIND_REG_DISC:
            st_d = known_q ? cac_pkg::ST_OUT : cac_pkg::ST_SUM_RD;
          cac_pkg::KIND_UNREG:  st_d = cac_pkg::ST_SUM_RD;
          cac_pkg::KIND_REQUEST, cac_pkg::KIND_FINISH: st_d = cac_pkg::ST_SCAN_RD;
          default:              st_d = cac_pkg::ST_OUT;
        endcase
      end
      cac_pkg::ST_SUM_RD:  st_d = cac_pkg::ST_SUM;
      cac_pkg::ST_SUM:
        if (idx_q == (SW+1)'(cac_pkg::ClientSlots - 1))
          st_d = (valid_q == '0) ? cac_pkg::ST_OUT : cac_pkg::ST_FQ_RD;
        else st_d = cac_pkg::ST_SUM_RD;
      cac_pkg::ST_FQ_RD:
        st_d = (idx_q == (SW+1)'(cac_pkg::ClientSlots) || tot_q == '0)
               ? cac_pkg::ST_DS : cac_pkg::ST_FQ_CHK;
      cac_pkg::ST_FQ_CHK:
        if (!(valid_q[idx_s] && slot_rd_q.is_fixed)) st_d = cac_pkg::ST_FQ_RD;
        else if (tot_q > TW'(max_fixed_q)) st_d = cac_pkg::ST_FQ_DIV;
        else st_d = cac_pkg::ST_FQ_WR;
      cac_pkg::ST_FQ_DIV:  if (drsp.done) st_d = cac_pkg::ST_FQ_WR;
      cac_pkg::ST_FQ_WR:   st_d = cac_pkg::ST_FQ_RD;
      cac_pkg::ST_DS:
        if (ndisc_q == '0) st_d = cac_pkg::ST_OUT;
        else if (TW'(max_total_q) > ref_v) st_d = cac_pkg::ST_DS_DIV;
        else st_d = cac_pkg::ST_OUT;
      cac_pkg::ST_DS_DIV:  if (drsp.done) st_d = cac_pkg::ST_OUT;
      cac_pkg::ST_SCAN_RD: st_d = cac_pkg::ST_SCAN;
      cac_pkg::ST_SCAN: begin
        if (sidx_q >= icnt_q) st_d = cac_pkg::ST_OUT;
        else if (kind_q == cac_pkg::KIND_FINISH && inf_rd_q == dev_q)
          st_d = cac_pkg::ST_SH_RD;
        else st_d = cac_pkg::ST_SCAN_RD;
      end
      cac_pkg::ST_SH_RD:
        st_d = (sidx_q + CW'(1) >= icnt_q) ? cac_pkg::ST_OUT : cac_pkg::ST_SH_WR;
      cac_pkg::ST_SH_WR:   st_d = cac_pkg::ST_SH_RD;
      cac_pkg::ST_OUT:     st_d = cac_pkg::ST_IDLE;
      default:             st_d = cac_pkg::ST_IDLE;
    endcase
  end

  assign ref_v = (tot_q < TW'(max_fixed_q)) ? tot_q : TW'(max_fixed_q);
  assign lim   = cur_q.is_fixed ? cur_q.quota : {3'b0, disc_q};

  // datapath and memory control
  always_comb begin
    valid_d = valid_q; disc_d = disc_q; icnt_d = icnt_q;
    kind_d = kind_q; cid_d = cid_q; dev_d = dev_q; cnt_d = cnt_q;
    idx_d = idx_q; sidx_d = sidx_q; match_d = match_q; tot_d = tot_q;
    ndisc_d = ndisc_q; known_d = known_q; gr_d = gr_q; ov_d = ov_q;
    cur_d = cur_q; act_d = act_q;
    slot_we = 1'b0; slot_wa = cid_q; slot_wd = cur_q; slot_ra = cid_q;
    inf_we = 1'b0; inf_wa = sidx_q[IW-1:0]; inf_wd = dev_q; inf_ra = sidx_q[IW-1:0];
    dreq = '0; q_v = '0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    unique case (st_q)
      cac_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        kind_d = s_axis_tuser; cid_d = s_axis_tdata[SW-1:0];
        dev_d = s_axis_tdata[35:4]; cnt_d = s_axis_tdata[45:36];
        slot_ra = s_axis_tdata[SW-1:0];
        gr_d = 1'b0; idx_d = '0; sidx_d = '0; match_d = '0; tot_d = '0; ndisc_d = '0;
      end
      cac_pkg::ST_RD: begin
        known_d = valid_q[cid_q];
        cur_d = slot_rd_q;
      end
      cac_pkg::ST_DEC: begin
        priority case (kind_q)
          cac_pkg::KIND_REG_FIXED, cac_pkg::KIND_REG_DISC: if (!known_q) begin
            valid_d[cid_q] = 1'b1;
            slot_we = 1'b1;
            slot_wd.is_fixed = (kind_q == cac_pkg::KIND_REG_FIXED);
            slot_wd.jobs = '0; slot_wd.quota = '0;
            slot_wd.declared = (kind_q == cac_pkg::KIND_REG_FIXED) ? cnt_q : '0;
          end
          cac_pkg::KIND_UNREG: if (known_q) begin
            valid_d[cid_q] = 1'b0;
            slot_we = 1'b1;
            slot_wd = cur_q; slot_wd.is_fixed = 1'b0; slot_wd.jobs = '0;
            slot_wd.quota = '0;
          end
          cac_pkg::KIND_REQUEST: begin
            if (!(CW'(icnt_q) < CW'(max_total_q) &&
                  icnt_q < CW'(cac_pkg::InflightDepth))) kind_d = cac_pkg::KIND_DENIED;
            else if (known_q && 10'(cur_q.jobs) >= lim) kind_d = cac_pkg::KIND_DENIED;
          end
          default: ;
        endcase
        slot_ra = '0;
      end
      cac_pkg::ST_SUM_RD: slot_ra = idx_s;
      cac_pkg::ST_SUM: begin
        if (valid_q[idx_s]) begin
          if (slot_rd_q.is_fixed) tot_d = tot_q + TW'(slot_rd_q.declared);
          else ndisc_d = ndisc_q + (SW+1)'(1);
        end
        idx_d = (idx_q == (SW+1)'(cac_pkg::ClientSlots - 1)) ? '0 : idx_q + (SW+1)'(1);
      end
      cac_pkg::ST_FQ_RD: slot_ra = idx_s;
      cac_pkg::ST_FQ_CHK: begin
        cur_d = slot_rd_q;
        if (!(valid_q[idx_s] && slot_rd_q.is_fixed)) idx_d = idx_q + (SW+1)'(1);
        else if (tot_q > TW'(max_fixed_q)) begin
          dreq.start = 1'b1;
          dreq.num = (TW+10)'(slot_rd_q.declared) * (TW+10)'(max_fixed_q);
          dreq.den = tot_q;
        end
      end
      cac_pkg::ST_FQ_DIV: if (drsp.done) cur_d.quota = drsp.quo[9:0];
      cac_pkg::ST_FQ_WR: begin
        q_v = (tot_q > TW'(max_fixed_q)) ? cur_q.quota : cur_q.declared;
        slot_we = 1'b1; slot_wa = idx_s;
        slot_wd = cur_q; slot_wd.quota = (q_v == '0) ? 10'd1 : q_v;
        idx_d = idx_q + (SW+1)'(1);
      end
      cac_pkg::ST_DS: if (ndisc_q != '0) begin
        if (TW'(max_total_q) > ref_v) begin
          dreq.start = 1'b1;
          dreq.num = (TW+10)'(TW'(max_total_q) - ref_v);
          dreq.den = TW'(ndisc_q);
        end else disc_d = 7'd1;
      end
      cac_pkg::ST_DS_DIV:
        if (drsp.done) disc_d = (drsp.quo == '0) ? 7'd1 : drsp.quo[6:0];
      cac_pkg::ST_SCAN_RD: inf_ra = sidx_q[IW-1:0];
      cac_pkg::ST_SCAN: begin
        if (sidx_q >= icnt_q) begin
          if (kind_q == cac_pkg::KIND_REQUEST && match_q < max_same_q) begin
            inf_we = 1'b1; inf_wa = icnt_q[IW-1:0];
            icnt_d = icnt_q + CW'(1); gr_d = 1'b1;
            if (known_q && cur_q.jobs < 7'd127) begin
              slot_we = 1'b1; slot_wd = cur_q; slot_wd.jobs = cur_q.jobs + 7'd1;
            end
          end
          if (kind_q == cac_pkg::KIND_FINISH && known_q && cur_q.jobs != '0) begin
            slot_we = 1'b1; slot_wd = cur_q; slot_wd.jobs = cur_q.jobs - 7'd1;
          end
        end else if (kind_q == cac_pkg::KIND_FINISH && inf_rd_q == dev_q) begin
          inf_ra = IW'(sidx_q + CW'(1));
        end else begin
          if (inf_rd_q == dev_q && match_q != 7'd127) match_d = match_q + 7'd1;
          sidx_d = sidx_q + CW'(1);
        end
      end
      cac_pkg::ST_SH_RD: begin
        // hold the read on entry sidx+1 for the move
        inf_ra = IW'(sidx_q + CW'(1));
        if (sidx_q + CW'(1) >= icnt_q) begin
          icnt_d = icnt_q - CW'(1);
          if (known_q && cur_q.jobs != '0) begin
            slot_we = 1'b1; slot_wd = cur_q; slot_wd.jobs = cur_q.jobs - 7'd1;
          end
        end
      end
      cac_pkg::ST_SH_WR: begin
        // move entry sidx+1 down, then fetch the next
        inf_we = 1'b1; inf_wa = sidx_q[IW-1:0]; inf_wd = inf_rd_q;
        sidx_d = sidx_q + CW'(1);
        inf_ra = IW'(sidx_q + CW'(2));
      end
      cac_pkg::ST_OUT: begin
        act_d = cac_pkg::ActW'($countones(valid_q));
        ov_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cac_pkg::ST_IDLE; valid_q <= '0; disc_q <= '0; icnt_q <= '0; ov_q <= 1'b0;
      gr_q <= 1'b0; act_q <= '0; kind_q <= '0; idx_q <= '0; sidx_q <= '0;
    end else begin
      st_q <= st_d; valid_q <= valid_d; disc_q <= disc_d; icnt_q <= icnt_d;
      ov_q <= ov_d; gr_q <= gr_d; act_q <= act_d; kind_q <= kind_d;
      idx_q <= idx_d; sidx_q <= sidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cid_q <= cid_d; dev_q <= dev_d; cnt_q <= cnt_d; match_q <= match_d;
    tot_q <= tot_d; ndisc_q <= ndisc_d; known_q <= known_d; cur_q <= cur_d;
  end
endmodule

### dv/tb_top.sv
// Self-checking testbench for the concurrency admission controller core.
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    logic       granted;
    logic [4:0] active;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // client_id[3:0], device_id[35:4], device_count[45:36]
  logic [2:0]  s_axis_tuser = '0;  // kind[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // active_clients[4:0]
  logic        m_axis_tuser;       // granted
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [9:0]  cfg_data_i = '0;

  // Admission state mirrored from the block's behaviour
  logic        slot_on[cac_pkg::ClientSlots];
  logic        slot_fixed[cac_pkg::ClientSlots];
  int unsigned slot_jobs[cac_pkg::ClientSlots];
  int unsigned slot_decl[cac_pkg::ClientSlots];
  int unsigned slot_quota[cac_pkg::ClientSlots];
  int unsigned disc_share;
  logic [31:0] busy_dev[cac_pkg::InflightDepth];
  int unsigned busy_cnt;
  int unsigned lim_total, lim_fixed, lim_same;

  verdict_t    pending_verdicts[$];
  int          mismatches = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  logic        hold_start = 1'b0;
  int          quiet_cycles = 0;
  logic [31:0] dev_pool[8];

  concurrency_admission_controller_core i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned registered_slots();
    int unsigned n;
    n = 0;
    for (int i = 0; i < cac_pkg::ClientSlots; i++) if (slot_on[i]) n++;
    return n;
  endfunction

  function automatic void rebalance_shares();
    int unsigned total, ndisc, q, floor_ref, d;
    total = 0;
    ndisc = 0;
    for (int i = 0; i < cac_pkg::ClientSlots; i++) begin
      if (!slot_on[i]) continue;
      if (slot_fixed[i]) total += slot_decl[i];
      else ndisc++;
    end
    if (registered_slots() == 0) return;
    if (total != 0) begin
      for (int i = 0; i < cac_pkg::ClientSlots; i++) begin
        if (!slot_on[i] || !slot_fixed[i]) continue;
        q = slot_decl[i];
        if (total > lim_fixed) q = (q * lim_fixed) / total;
        if (q == 0) q = 1;
        slot_quota[i] = q & 10'h3ff;
      end
    end
    if (ndisc != 0) begin
      floor_ref = (total < lim_fixed) ? total : lim_fixed;
      if (lim_total > floor_ref) begin
        d = (lim_total - floor_ref) / ndisc;
        disc_share = (d > 0) ? (d & 7'h7f) : 1;
      end else begin
        disc_share = 1;
      end
    end
  endfunction

  function automatic verdict_t predict_admission(logic [2:0] kind, logic [3:0] cid,
                                                 logic [31:0] dev, logic [9:0] cnt);
    verdict_t    v;
    logic        known, ok;
    int unsigned lim, same;
    known = slot_on[cid];
    v.granted = 1'b0;
    case (kind)
      cac_pkg::KIND_REG_FIXED, cac_pkg::KIND_REG_DISC: begin
        if (!known) begin
          slot_on[cid]    = 1'b1;
          slot_fixed[cid] = (kind == cac_pkg::KIND_REG_FIXED);
          slot_jobs[cid]  = 0;
          slot_quota[cid] = 0;
          slot_decl[cid]  = (kind == cac_pkg::KIND_REG_FIXED) ? cnt : 0;
          rebalance_shares();
        end
      end
      cac_pkg::KIND_UNREG: begin
        if (known) begin
          slot_on[cid]    = 1'b0;
          slot_fixed[cid] = 1'b0;
          slot_jobs[cid]  = 0;
          slot_quota[cid] = 0;
        end
        rebalance_shares();
      end
      cac_pkg::KIND_REQUEST: begin
        ok = (busy_cnt < lim_total) && (busy_cnt < cac_pkg::InflightDepth);
        if (ok && known) begin
          lim = slot_fixed[cid] ? slot_quota[cid] : disc_share;
          if (slot_jobs[cid] >= lim) ok = 1'b0;
        end
        if (ok) begin
          same = 0;
          for (int i = 0; i < busy_cnt; i++) if (busy_dev[i] == dev) same++;
          if (same < lim_same) begin
            busy_dev[busy_cnt] = dev;
            busy_cnt++;
            if (known && slot_jobs[cid] < 127) slot_jobs[cid]++;
            v.granted = 1'b1;
          end
        end
      end
      cac_pkg::KIND_FINISH: begin
        for (int i = 0; i < busy_cnt; i++) begin
          if (busy_dev[i] == dev) begin
            for (int j = i; j + 1 < busy_cnt; j++) busy_dev[j] = busy_dev[j + 1];
            busy_cnt--;
            break;
          end
        end
        if (known && slot_jobs[cid] > 0) slot_jobs[cid]--;
      end
      default: ;
    endcase
    v.active = 5'(registered_slots());
    return v;
  endfunction

  // Offer one item, hold it until transfer, then log the expected verdict
  task automatic send_item(logic [2:0] kind, logic [3:0] cid, logic [31:0] dev,
                           logic [9:0] cnt);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'd0, cnt, dev, cid};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_verdicts.push_back(predict_admission(kind, cid, dev, cnt));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(cac_pkg::cfg_idx_e idx, int unsigned val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[9:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      cac_pkg::CFG_MAX_TOTAL:    lim_total = val & 7'h7f;
      cac_pkg::CFG_MAX_FIXED:    lim_fixed = val & 10'h3ff;
      cac_pkg::CFG_MAX_SAME_DEV: lim_same  = val & 7'h7f;
      default: ;
    endcase
  endtask

  task automatic test_directed();
    write_limit(cac_pkg::CFG_MAX_TOTAL, 64);
    write_limit(cac_pkg::CFG_MAX_FIXED, 1023);
    write_limit(cac_pkg::CFG_MAX_SAME_DEV, 4);
    send_item(cac_pkg::KIND_REG_FIXED, 4'd0, 32'd0, 10'd1023);
    send_item(cac_pkg::KIND_REG_FIXED, 4'd15, 32'hffff_ffff, 10'd0);
    send_item(cac_pkg::KIND_REG_DISC, 4'd5, 32'd0, 10'd0);
    send_item(cac_pkg::KIND_REG_FIXED, 4'd0, 32'd0, 10'd3);       // already known
    send_item(cac_pkg::KIND_UNREG, 4'd9, 32'd0, 10'd0);           // unknown slot
    send_item(cac_pkg::KIND_REQUEST, 4'd7, 32'hffff_ffff, 10'd0); // unregistered client
    for (int i = 0; i < 5; i++) send_item(cac_pkg::KIND_REQUEST, 4'd0, 32'd0, 10'd0);
    send_item(cac_pkg::KIND_FINISH, 4'd5, 32'hdead_beef, 10'd0);  // no matching device
    send_item(cac_pkg::KIND_FINISH, 4'd0, 32'd0, 10'd0);
    send_item(3'd5, 4'd1, 32'd1, 10'd1);
    send_item(3'd6, 4'd2, 32'd2, 10'd2);
    send_item(3'd7, 4'd3, 32'd3, 10'd3);
    send_item(cac_pkg::KIND_UNREG, 4'd0, 32'd0, 10'd0);           // fixed total drops to zero
    send_item(cac_pkg::KIND_REQUEST, 4'd5, 32'd7, 10'd0);
    send_item(cac_pkg::KIND_UNREG, 4'd15, 32'd0, 10'd0);
    send_item(cac_pkg::KIND_UNREG, 4'd5, 32'd0, 10'd0);           // recompute with no slots
  endtask

  task automatic test_store_full();
    write_limit(cac_pkg::CFG_MAX_TOTAL, 64);
    write_limit(cac_pkg::CFG_MAX_SAME_DEV, 64);
    write_limit(cac_pkg::CFG_MAX_FIXED, 0);
    for (int i = 0; i < 68; i++)
      send_item(cac_pkg::KIND_REQUEST, 4'd12, dev_pool[i % 8], 10'd0);
  endtask

  function automatic logic [2:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 10) return cac_pkg::KIND_REG_FIXED;
    if (r < 16) return cac_pkg::KIND_REG_DISC;
    if (r < 22) return cac_pkg::KIND_UNREG;
    if (r < 62) return cac_pkg::KIND_REQUEST;
    if (r < 95) return cac_pkg::KIND_FINISH;
    return 3'($urandom_range(7, 5));
  endfunction

  task automatic test_random(int n, int idle, int stall);
    logic [31:0] dev;
    logic [9:0]  cnt;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      dev = ($urandom_range(9) == 0) ? $urandom() : dev_pool[$urandom_range(7)];
      cnt = ($urandom_range(7) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(20));
      send_item(pick_kind(), 4'($urandom_range(15)), dev, cnt);
    end
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    for (int i = 0; i < 20; i++)
      send_item(cac_pkg::KIND_REQUEST, 4'($urandom_range(15)), dev_pool[$urandom_range(7)],
                10'd0);
    drain_results();
    for (int i = 0; i < 10; i++)
      send_item(cac_pkg::KIND_FINISH, 4'($urandom_range(15)), dev_pool[$urandom_range(7)],
                10'd0);
  endtask

  task automatic reconfigure();
    write_limit(cac_pkg::CFG_MAX_TOTAL, $urandom_range(64, 1));
    write_limit(cac_pkg::CFG_MAX_FIXED, $urandom_range(1023));
    write_limit(cac_pkg::CFG_MAX_SAME_DEV, $urandom_range(64, 1));
  endtask

  // Result checker
  always @(posedge clk_i) begin
    verdict_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: granted %0b active %0d",
                                       m_axis_tuser, m_axis_tdata[4:0]);
      end else begin
        want = pending_verdicts.pop_front();
        if (want.granted !== m_axis_tuser || want.active !== m_axis_tdata[4:0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result differs: granted exp %0b got %0b, active exp %0d got %0d",
                     want.granted, m_axis_tuser, want.active, m_axis_tdata[4:0]);
        end
      end
    end
  end

  // Receiver: random stalls, and a long hold counted down here
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: any transfer restarts the count
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("concurrency_admission_controller_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < cac_pkg::ClientSlots; i++) begin
      slot_on[i] = 1'b0;
      slot_fixed[i] = 1'b0;
      slot_jobs[i] = 0;
      slot_decl[i] = 0;
      slot_quota[i] = 0;
    end
    disc_share = 0;
    busy_cnt   = 0;
    lim_total  = cac_pkg::RstMaxTotal;
    lim_fixed  = cac_pkg::RstMaxFixed;
    lim_same   = cac_pkg::RstMaxSameDev;
    dev_pool[0] = 32'd0;
    dev_pool[1] = 32'hffff_ffff;
    for (int i = 2; i < 8; i++) dev_pool[i] = $urandom();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limits first, untouched
    test_random(40, 0, 0);
    test_directed();
    test_store_full();
    test_random(100, 0, 0);
    write_limit(cac_pkg::CFG_MAX_TOTAL, 1);
    write_limit(cac_pkg::CFG_MAX_FIXED, 0);
    write_limit(cac_pkg::CFG_MAX_SAME_DEV, 1);
    test_random(130, 54, 0);
    reconfigure();
    test_backpressure();
    test_random(130, 0, 54);
    write_limit(cac_pkg::CFG_MAX_TOTAL, 63);
    write_limit(cac_pkg::CFG_MAX_FIXED, 512);
    write_limit(cac_pkg::CFG_MAX_SAME_DEV, 64);
    test_random(100, 15, 15);
    drain_results();
    repeat (300) @(posedge clk_i);

    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("concurrency_admission_controller_core: match");
    end else begin
      $display("concurrency_admission_controller_core: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/cac_pkg.sv
rtl/cac_div.sv
rtl/concurrency_admission_controller_core.sv
dv/tb_top.sv
